// ----- rtl/cbts_pkg.sv -----
// ----------------------------------------------------------------------------
// cbts_pkg: shared definitions for the CAN bit timing solver
// Default limits for prescaler and time segments, and the result status codes.
// ----------------------------------------------------------------------------
package cbts_pkg;

  // Default limits on the solved bit timing
  localparam int DEF_MAX_PRESCALER = 1024;
  localparam int DEF_MAX_SEG1      = 16;
  localparam int DEF_MAX_SEG2      = 8;

  // Result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

endpackage

// ----- rtl/can_bit_timing_solver_unit.sv -----
// ----------------------------------------------------------------------------
// can_bit_timing_solver_unit: CAN bit timing solver
// Derives prescaler and time segment fields from kernel clock, bit rate and
// sample point, one request at a time, with a bit-serial datapath.
// ----------------------------------------------------------------------------
// One request is taken while the solver is idle; the result beat then comes
// out of an output register, and a new request may be taken while it waits.
// After acceptance a request goes through the bit-serial quantum divide, the
// sample point multiply and the segment two check. Up to three attempts
// follow. Each is a binary GCD together with the shift back of the shared
// twos (GW = 15 bits at the default limits), a bit-serial divide of both
// segments by the prescaler, and setup and range checks. The result register
// loads after the last check, once the output register is free. A zero bit
// rate, or a segment two out of range, goes straight to the failure state
// and loads an error result.
// ----------------------------------------------------------------------------
module can_bit_timing_solver_unit #(
  parameter int MAX_PRESCALER = cbts_pkg::DEF_MAX_PRESCALER,
  parameter int MAX_SEG1      = cbts_pkg::DEF_MAX_SEG1,
  parameter int MAX_SEG2      = cbts_pkg::DEF_MAX_SEG2,
  localparam int PRE_W  = $clog2(MAX_PRESCALER),
  localparam int SEG1_W = (MAX_SEG1 > 1) ? $clog2(MAX_SEG1) : 1,
  localparam int SEG2_W = (MAX_SEG2 > 1) ? $clog2(MAX_SEG2) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       clock_hz,
  input  logic [19:0]       bit_rate,
  input  logic [15:0]       sample_point,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PRE_W-1:0]  prescaler_field,
  output logic [SEG1_W-1:0] seg1_field,
  output logic [SEG2_W-1:0] seg2_field,
  output logic              status
);
  import cbts_pkg::*;

  // Largest segment values that can still give a legal timing
  localparam int T1_MAX = MAX_PRESCALER * (MAX_SEG1 + 1);
  localparam int T2_MAX = MAX_PRESCALER * MAX_SEG2;
  localparam int T_MAX  = (T1_MAX > T2_MAX) ? T1_MAX : T2_MAX;
  localparam int GW     = $clog2(T_MAX + 1);
  localparam int KW     = $clog2(GW + 1);
  localparam int CW     = $clog2(((GW > 32) ? GW : 32) + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_MUL, S_SEG, S_TRY, S_GCD, S_SCALE,
    S_CHECK_P, S_QUOT, S_CHECK_Q, S_FAIL, S_EMIT
  } state_t;

  typedef enum logic [1:0] {ATT_BASE, ATT_UP, ATT_DOWN} att_t;

  state_t          state;
  att_t            att;
  logic [CW-1:0]   cnt;
  logic [19:0]     rate;
  logic [31:0]     dq;
  logic [19:0]     rem;
  logic [15:0]     spl;
  logic [31:0]     hi;
  logic [31:0]     qv;
  logic [GW-1:0]   t1;
  logic [GW-1:0]   t2;
  logic [GW-1:0]   a;
  logic [GW-1:0]   b;
  logic [KW-1:0]   k;
  logic [GW-1:0]   n1;
  logic [GW-1:0]   n2;
  logic [GW-1:0]   r1;
  logic [GW-1:0]   r2;
  logic            res_err;

  logic [20:0]     div_sh;
  logic [21:0]     div_diff;
  logic            div_ok;
  logic [32:0]     mul_sum;
  logic [31:0]     t2_full;
  logic [32:0]     t1_cand;
  logic            t1_skip;
  logic [GW:0]     q1_sh;
  logic [GW:0]     q2_sh;
  logic [GW+1:0]   q1_diff;
  logic [GW+1:0]   q2_diff;
  logic            q1_ok;
  logic            q2_ok;
  logic [GW-1:0]   pm1;
  logic [GW-1:0]   s1m2;
  logic [GW-1:0]   s2m1;
  logic            p_ok;
  logic            q_ok;
  att_t            att_next;

  // Restoring divide step: quantum count from clock and bit rate
  always_comb begin
    div_sh   = {rem, dq[31]};
    div_diff = {1'b0, div_sh} - {2'b00, rate};
    div_ok   = !div_diff[21];
  end

  // Shift-add multiply step: quanta times sample point
  assign mul_sum = {1'b0, hi} + (spl[0] ? {1'b0, qv} : 33'd0);
  assign t2_full = qv - hi;

  // Segment one candidate for the current attempt
  always_comb begin
    t1_skip  = 1'b0;
    att_next = ATT_DOWN;
    unique case (att)
      ATT_BASE: begin
        t1_cand  = {1'b0, hi};
        att_next = ATT_UP;
      end
      ATT_UP: begin
        t1_cand  = {1'b0, hi} + 33'd1;
        att_next = ATT_DOWN;
      end
      default: begin
        t1_cand = {1'b0, hi} - 33'd1;
        t1_skip = (hi == 32'd0);
      end
    endcase
  end

  // Restoring divide step of both segments by the prescaler in a
  always_comb begin
    q1_sh   = {r1, n1[GW-1]};
    q2_sh   = {r2, n2[GW-1]};
    q1_diff = {1'b0, q1_sh} - {2'b00, a};
    q2_diff = {1'b0, q2_sh} - {2'b00, a};
    q1_ok   = !q1_diff[GW+1];
    q2_ok   = !q2_diff[GW+1];
  end

  // Range checks and register field values
  always_comb begin
    p_ok = (a >= GW'(2)) && (a <= GW'(MAX_PRESCALER));
    q_ok = (n1 >= GW'(2)) && (n1 <= GW'(MAX_SEG1 + 1)) &&
           (n2 >= GW'(1)) && (n2 <= GW'(MAX_SEG2));
    pm1  = a - GW'(1);
    s1m2 = n1 - GW'(2);
    s2m1 = n2 - GW'(1);
  end

  assign in_ready = (state == S_IDLE);

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      att       <= ATT_BASE;
      cnt       <= '0;
      out_valid <= 1'b0;
      res_err   <= 1'b0;
    end else begin
      // Drop the result once taken; the emit state handles its own beat
      if (out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            rate  <= bit_rate;
            dq    <= clock_hz;
            rem   <= '0;
            spl   <= sample_point;
            cnt   <= CW'(32);
            state <= (bit_rate == 20'd0) ? S_FAIL : S_DIV;
          end
        end
        S_DIV: begin
          dq  <= {dq[30:0], div_ok};
          rem <= div_ok ? div_diff[19:0] : div_sh[19:0];
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            qv    <= {dq[30:0], div_ok};
            hi    <= '0;
            cnt   <= CW'(16);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          hi  <= mul_sum[32:1];
          spl <= {mul_sum[0], spl[15:1]};
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= S_SEG;
          end
        end
        S_SEG: begin
          // Segment two must be nonzero and small enough for some prescaler
          if (t2_full == 32'd0 || t2_full > 32'(T2_MAX)) begin
            state <= S_FAIL;
          end else begin
            t2    <= t2_full[GW-1:0];
            att   <= ATT_BASE;
            state <= S_TRY;
          end
        end
        S_TRY: begin
          if (t1_skip || t1_cand == 33'd0 || t1_cand > 33'(T1_MAX)) begin
            if (att == ATT_DOWN) begin
              state <= S_FAIL;
            end else begin
              att <= att_next;
            end
          end else begin
            t1    <= t1_cand[GW-1:0];
            a     <= t1_cand[GW-1:0];
            b     <= t2;
            k     <= '0;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          // Binary GCD: strip shared twos, strip odd twos, subtract
          if (!a[0] && !b[0]) begin
            a <= a >> 1;
            b <= b >> 1;
            k <= k + KW'(1);
          end else if (!a[0]) begin
            a <= a >> 1;
          end else if (!b[0]) begin
            b <= b >> 1;
          end else if (a == b) begin
            state <= S_SCALE;
          end else if (a > b) begin
            a <= a - b;
          end else begin
            b <= b - a;
          end
        end
        S_SCALE: begin
          // Restore the shared powers of two, one bit per cycle
          if (k != '0) begin
            a <= a << 1;
            k <= k - KW'(1);
          end else begin
            state <= S_CHECK_P;
          end
        end
        S_CHECK_P: begin
          if (p_ok) begin
            n1    <= t1;
            n2    <= t2;
            r1    <= '0;
            r2    <= '0;
            cnt   <= CW'(GW);
            state <= S_QUOT;
          end else if (att == ATT_DOWN) begin
            state <= S_FAIL;
          end else begin
            att   <= att_next;
            state <= S_TRY;
          end
        end
        S_QUOT: begin
          n1  <= {n1[GW-2:0], q1_ok};
          n2  <= {n2[GW-2:0], q2_ok};
          r1  <= q1_ok ? q1_diff[GW-1:0] : q1_sh[GW-1:0];
          r2  <= q2_ok ? q2_diff[GW-1:0] : q2_sh[GW-1:0];
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= S_CHECK_Q;
          end
        end
        S_CHECK_Q: begin
          if (q_ok) begin
            res_err <= 1'b0;
            state   <= S_EMIT;
          end else if (att == ATT_DOWN) begin
            state <= S_FAIL;
          end else begin
            att   <= att_next;
            state <= S_TRY;
          end
        end
        S_FAIL: begin
          res_err <= 1'b1;
          state   <= S_EMIT;
        end
        S_EMIT: begin
          // Load the result beat once the output register is free
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            status          <= res_err ? STATUS_ERR : STATUS_OK;
            prescaler_field <= res_err ? '0 : pm1[PRE_W-1:0];
            seg1_field      <= res_err ? '0 : s1m2[SEG1_W-1:0];
            seg2_field      <= res_err ? '0 : s2m1[SEG2_W-1:0];
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/cbts_checker.sv -----
// ----------------------------------------------------------------------------
// cbts_checker: port-level checks for the CAN bit timing solver
// Watches the request and result channels and the result encoding.
// ----------------------------------------------------------------------------
module cbts_checker #(
  parameter int PRE_W  = $clog2(cbts_pkg::DEF_MAX_PRESCALER),
  parameter int SEG1_W = $clog2(cbts_pkg::DEF_MAX_SEG1),
  parameter int SEG2_W = $clog2(cbts_pkg::DEF_MAX_SEG2)
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [PRE_W-1:0]  prescaler_field,
  input logic [SEG1_W-1:0] seg1_field,
  input logic [SEG2_W-1:0] seg2_field,
  input logic              status
);
  import cbts_pkg::*;

  // An error beat carries all-zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_ERR |->
      prescaler_field == '0 && seg1_field == '0 && seg2_field == '0)
    else $error("error result with nonzero fields");

  // A solved timing never has a prescaler below two
  a_pre_min: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_OK |-> prescaler_field != '0)
    else $error("solved prescaler below two");

  // The solver works on one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(prescaler_field) && $stable(seg1_field) && $stable(seg2_field))
    else $error("stalled result changed");

endmodule

bind can_bit_timing_solver_unit cbts_checker #(
  .PRE_W  (PRE_W),
  .SEG1_W (SEG1_W),
  .SEG2_W (SEG2_W)
) u_cbts_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .prescaler_field (prescaler_field),
  .seg1_field      (seg1_field),
  .seg2_field      (seg2_field),
  .status          (status)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for can_bit_timing_solver_unit
// Offers bit timing requests, predicts each result with an independent
// solver that walks the three segment-one candidates, and checks every
// result beat field by field in order. Covers corner cases, well-formed
// timings built from chosen prescaler and segments, malformed requests,
// random idling on both sides, and a long output stall.
// ----------------------------------------------------------------------------
module tb;
  import cbts_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 400;
  localparam int STALL_CYCLES   = 600;

  typedef struct packed {
    logic [9:0] prescaler;
    logic [3:0] seg1;
    logic [2:0] seg2;
    logic       status;
  } timing_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] clock_hz = '0;
  logic [19:0] bit_rate = '0;
  logic [15:0] sample_point = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  prescaler_field;
  logic [3:0]  seg1_field;
  logic [2:0]  seg2_field;
  logic        status;

  timing_t timing_q[$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_cycles = 0;

  can_bit_timing_solver_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .clock_hz(clock_hz),
    .bit_rate(bit_rate),
    .sample_point(sample_point),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .prescaler_field(prescaler_field),
    .seg1_field(seg1_field),
    .seg2_field(seg2_field),
    .status(status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Solve one request: quanta per bit, split at the sample point, then try
  // segment one as is, plus one and minus one against a fixed segment two.
  function automatic timing_t solve_timing(logic [31:0] clk_hz, logic [19:0] rate,
                                           logic [15:0] sp);
    timing_t res;
    logic [63:0] quanta, base1, tseg2, tseg1, a, b, r, pre, s1q, s2q;
    res = '0;
    res.status = STATUS_ERR;
    if (rate == 0) return res;
    quanta = 64'(clk_hz) / 64'(rate);
    base1 = (quanta * 64'(sp)) >> 16;
    tseg2 = quanta - base1;
    if (tseg2 == 0) return res;
    for (int i = 0; i < 3; i++) begin
      if (i == 0) tseg1 = base1;
      else if (i == 1) tseg1 = base1 + 1;
      else begin
        if (base1 == 0) continue;
        tseg1 = base1 - 1;
      end
      a = tseg1;
      b = tseg2;
      while (b != 0) begin
        r = a % b;
        a = b;
        b = r;
      end
      pre = a;
      if (pre == 0) continue;
      s1q = tseg1 / pre;
      s2q = tseg2 / pre;
      if (pre < 2 || pre > DEF_MAX_PRESCALER) continue;
      if (s1q < 2 || s1q > DEF_MAX_SEG1 + 1) continue;
      if (s2q < 1 || s2q > DEF_MAX_SEG2) continue;
      res.prescaler = 10'(pre - 1);
      res.seg1      = 4'(s1q - 2);
      res.seg2      = 3'(s2q - 1);
      res.status    = STATUS_OK;
      return res;
    end
    return res;
  endfunction

  // Check each result beat against the oldest prediction, then record new requests
  always @(posedge clk) begin
    timing_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (timing_q.size() == 0) begin
          $error("result beat with no request pending");
          mismatches++;
        end else begin
          want = timing_q.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatches++;
          end
          if (prescaler_field !== want.prescaler) begin
            $error("prescaler_field: expected %0d, got %0d", want.prescaler, prescaler_field);
            mismatches++;
          end
          if (seg1_field !== want.seg1) begin
            $error("seg1_field: expected %0d, got %0d", want.seg1, seg1_field);
            mismatches++;
          end
          if (seg2_field !== want.seg2) begin
            $error("seg2_field: expected %0d, got %0d", want.seg2, seg2_field);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        timing_q.push_back(solve_timing(clock_hz, bit_rate, sample_point));
    end
  end

  // Drive output ready: long hold-off when requested, else random stalls
  initial begin
    forever begin
      @(posedge clk);
      if (rst) out_ready <= 1'b0;
      else if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // End the run when no beat moves on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL can_bit_timing_solver_unit");
      $finish;
    end
  end

  // Offer one request, with random idle cycles ahead, and hold until accepted
  task automatic send_request(logic [31:0] hz, logic [19:0] rate, logic [15:0] sp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    clock_hz     <= hz;
    bit_rate     <= rate;
    sample_point <= sp;
    do @(posedge clk); while (!in_ready);
  endtask

  // Build a request whose quanta split into prescaler * (seg1 + seg2), with
  // segment one shifted so the match lands on the first, second or third try
  task automatic send_timing(int pre, int s1q, int s2q, int shift);
    longint base1, quanta, rate_max, rate, hz;
    logic [15:0] sp;
    base1 = longint'(pre) * s1q + shift;
    quanta = base1 + longint'(pre) * s2q;
    sp = 16'((base1 * 65536 + quanta - 1) / quanta);
    rate_max = 64'hFFFF_FFFF / (quanta + 1);
    if (rate_max > 20'hFFFFF) rate_max = 20'hFFFFF;
    rate = $urandom_range(int'(rate_max), 1);
    hz = quanta * rate + $urandom_range(int'(rate) - 1, 0);
    send_request(32'(hz), 20'(rate), sp);
  endtask

  task automatic send_random_timing();
    int pre;
    pre = ($urandom_range(9) == 0) ? $urandom_range(1025, 1) : $urandom_range(64, 2);
    send_timing(pre, $urandom_range(18, 1), $urandom_range(9, 1), int'($urandom_range(2)) - 1);
  endtask

  // Stop offering and wait until every recorded request has its result
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (timing_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_idle_mix(int phase);
    case (phase)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
      default: begin send_idle_pct = 14; recv_stall_pct = 14; end
    endcase
  endtask

  // Field extremes and the named special cases
  task automatic test_corner_cases();
    set_idle_mix(0);
    send_request(32'd0, 20'd1, 16'd0);                     // clock below rate: no quanta
    send_request(32'hFFFF_FFFF, 20'd0, 16'hFFFF);          // zero bit rate
    send_request(32'hFFFF_FFFF, 20'd1, 16'hFFFF);          // huge quanta count
    send_request(32'hFFFF_FFFF, 20'hFFFFF, 16'h8000);
    send_request(32'd1, 20'hFFFFF, 16'd0);
    send_request(32'd8_000_000, 20'd500_000, 16'hE000);    // plain solvable case
    send_request(32'd8_000_000, 20'd500_000, 16'd0);       // segment one of zero
    send_request(32'd8_000_000, 20'd500_000, 16'hFFFF);
    send_request(32'd16, 20'd16, 16'hFFFF);                // one quantum, all segment two
    send_timing(2, 2, 1, 0);                               // smallest valid timing
    send_timing(1024, 17, 8, 0);                           // largest valid timing
    send_timing(1024, 17, 8, 1);                           // match on the minus-one try
    send_timing(4, 5, 3, -1);                              // match on the plus-one try
    send_timing(2, 18, 1, 0);                              // segment one too long
    send_timing(2, 17, 9, 0);                              // segment two too long
    send_timing(1025, 2, 1, 0);                            // prescaler too large
    send_timing(1, 5, 3, 0);
    send_timing(3, 1, 4, 0);                               // segment one without sync room
    send_timing(2, 1, 1, -1);
    wait_results_drained();
  endtask

  // Well-formed timings under each idle mix
  task automatic test_timing_search();
    for (int ph = 0; ph < 4; ph++) begin
      set_idle_mix(ph);
      repeat (110) send_random_timing();
      wait_results_drained();
    end
  endtask

  // Random fields, tiny quanta counts and zero rates under each idle mix
  task automatic test_malformed_requests();
    longint unsigned rate;
    for (int ph = 0; ph < 4; ph++) begin
      set_idle_mix(ph);
      repeat (40) begin
        rate = $urandom_range(20'hFFFFF, 1);
        case ($urandom_range(2))
          0: send_request($urandom, 20'($urandom_range(20'hFFFFF, 0)), 16'($urandom));
          1: send_request(32'(rate * $urandom_range(30000, 1)), 20'(rate), 16'($urandom));
          default: send_request(32'($urandom_range(int'(rate) - 1, 0)),
                                ($urandom_range(1) == 0) ? 20'd0 : 20'(rate), 16'($urandom));
        endcase
      end
      wait_results_drained();
    end
  endtask

  // Hold the output off for a long stretch while requests keep coming
  task automatic test_output_stall();
    set_idle_mix(0);
    hold_cycles = STALL_CYCLES;
    repeat (24) send_random_timing();
    wait_results_drained();
    repeat (6) send_random_timing();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_corner_cases();
    test_timing_search();
    test_malformed_requests();
    test_output_stall();
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && timing_q.size() == 0) begin
      $display("PASS can_bit_timing_solver_unit");
    end else begin
      $display("FAIL can_bit_timing_solver_unit");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cbts_pkg.sv
rtl/can_bit_timing_solver_unit.sv
rtl/cbts_checker.sv
tb/tb.sv
